FILE: hw/rtl/mcdp_pkg.sv
// Shared types and constants for the matrix chain order block.
// Depends on nothing; every other file of the block imports it.

package mcdp_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int DIM_W     = 16;
   localparam int OUT_IDX_W = 4;
   localparam int COST_W    = 63;
   localparam int SPLIT_W   = 4;

   // Multiplier operand and product widths: p*p fits 32 bits, p*p*p fits 48.
   localparam int MULA_W = 2 * DIM_W;
   localparam int PROD_W = 3 * DIM_W;

   localparam logic [COST_W-1:0] COST_CAP = {COST_W{1'b1}};

   // One stored table entry: best split and minimal cost of a subchain.
   typedef struct packed {
      logic [SPLIT_W-1:0] split;
      logic [COST_W-1:0]  cost;
   } entry_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAIR_A,
      ST_PAIR_B,
      ST_PAIR_C,
      ST_PAIR_D,
      ST_K_RD,
      ST_K_MUL,
      ST_K_ADD,
      ST_K_CMP,
      ST_DUMP_RD,
      ST_DUMP_LD,
      ST_SINGLE
   } state_type;

   // Operation of the shared saturating adder.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_PAIR,
      ACC_PROD
   } acc_op_type;

   // Control from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic       load_dim;
      logic       load_prod;
      logic       mul_en;
      acc_op_type acc_op;
      logic       left_zero;
      logic       right_zero;
      logic       cmp_en;
      logic       first_k;
   } arith_ctl_type;

endpackage

FILE: hw/rtl/mcdp_if.sv
// Valid/ready channel interfaces for the dimension input and the result output.
// Depends on mcdp_pkg for the payload widths.

interface mcdp_req_if import mcdp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DIM_W-1:0] dimension;
   logic             last_dimension;

   modport source (output valid, output dimension, output last_dimension, input ready);
   modport sink (input valid, input dimension, input last_dimension, output ready);
endinterface

interface mcdp_rsp_if import mcdp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] row_index;
   logic [OUT_IDX_W-1:0] col_index;
   logic [COST_W-1:0]    min_cost;
   logic [SPLIT_W-1:0]   best_split;
   logic                 last_result;

   modport source (output valid, output row_index, output col_index, output min_cost,
                   output best_split, output last_result, input ready);
   modport sink (input valid, input row_index, input col_index, input min_cost,
                 input best_split, input last_result, output ready);
endinterface

FILE: hw/rtl/matrix_chain_order_dp.sv
// Matrix chain order: loads one dimension per cycle while idle; the marked dimension
// starts the interval program, one subchain i<j after another through the one shared
// multiplier and saturating adder, then dumps the results while the output is taken
// (28 results for eight matrices).
// Reset is synchronous and active high; it clears the sequencer, the dimension count
// and the result valid. The tables need no clearing: every entry used is written first.

module matrix_chain_order_dp import mcdp_pkg::*; #(
   parameter int MAX_MATRICES = 8
) (
   input logic             clock,
   input logic             reset,
   mcdp_req_if.sink        req_ch,
   mcdp_rsp_if.source      rsp_ch
);

   localparam int SLOTS    = MAX_MATRICES + 1;
   localparam int IDX_W    = $clog2(MAX_MATRICES + 1);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int DEPTH    = MAX_MATRICES * MAX_MATRICES;
   localparam int CA_W     = $clog2(DEPTH);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     n_ff, n_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]     best_k_ff, best_k_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_IDX_W-1:0] rsp_col_ff, rsp_col_in;
   logic [COST_W-1:0]    rsp_cost_ff, rsp_cost_in;
   logic [SPLIT_W-1:0]   rsp_split_ff, rsp_split_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_load;
   logic                 out_free;

   logic                 req_ready;
   logic                 req_take;
   logic                 store_ok;
   logic [CNT_W-1:0]     count_after;
   logic [IDX_W-1:0]     n_calc;

   logic                 dim_wr_en;
   logic [IDX_W-1:0]     dim_rd_addr;
   logic [DIM_W-1:0]     dim_rd;

   logic                 cost_wr_en;
   entry_type            cost_wr_data;
   logic [CA_W-1:0]      cost_addr_a;
   logic [CA_W-1:0]      cost_addr_b;
   entry_type            cost_rd_a;
   entry_type            cost_rd_b;

   arith_ctl_type        ctl;
   logic                 take;
   logic [COST_W-1:0]    acc;
   logic [COST_W-1:0]    best;
   logic                 dump_last;

   // Row-major table address of subchain row..col, both 1-based.
   function automatic logic [CA_W-1:0] cost_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
      int lin;
      lin = (int'(row) - 1) * MAX_MATRICES + int'(col) - 1;
      return CA_W'(lin);
   endfunction

   // Input bookkeeping: dimensions past the last slot are dropped.
   assign req_take    = req_ch.valid && req_ready;
   assign store_ok    = count_ff < CNT_W'(SLOTS);
   assign count_after = count_ff + CNT_W'(store_ok);
   assign n_calc      = IDX_W'(count_after - CNT_W'(1));
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign dump_last   = (i_ff == n_ff - IDX_W'(1)) && (j_ff == n_ff);

   mcdp_dim_store #(
      .SLOTS  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_dim_store (
      .clock   (clock),
      .wr_en   (dim_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_ch.dimension),
      .rd_addr (dim_rd_addr),
      .rd_data (dim_rd)
   );

   mcdp_cost_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (CA_W)
   ) u_cost_ram (
      .clock     (clock),
      .wr_en     (cost_wr_en),
      .wr_addr   (cost_addr(i_ff, j_ff)),
      .wr_data   (cost_wr_data),
      .rd_addr_a (cost_addr_a),
      .rd_addr_b (cost_addr_b),
      .rd_data_a (cost_rd_a),
      .rd_data_b (cost_rd_b)
   );

   mcdp_arith u_arith (
      .clock      (clock),
      .ctl        (ctl),
      .dim_rd     (dim_rd),
      .left_cost  (cost_rd_a.cost),
      .right_cost (cost_rd_b.cost),
      .take       (take),
      .acc        (acc),
      .best       (best)
   );

   // Sequencer state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Index and result payload registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      best_k_ff    <= best_k_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_split_ff <= rsp_split_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Next state and control: loading, the split search per subchain, the dump.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      best_k_in    = best_k_ff;
      req_ready    = 1'b0;
      dim_wr_en    = 1'b0;
      dim_rd_addr  = i_ff - IDX_W'(1);
      cost_wr_en   = 1'b0;
      cost_wr_data = '{split: SPLIT_W'(take ? k_ff : best_k_ff),
                       cost: (take ? acc : best)};
      cost_addr_a  = cost_addr(i_ff, j_ff);
      cost_addr_b  = cost_addr(k_ff + IDX_W'(1), j_ff);
      ctl          = '{acc_op: ACC_HOLD, default: 1'b0};
      rsp_load     = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_split_in = rsp_split_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_take) begin
               dim_wr_en = store_ok;
               count_in  = count_after;
               if (req_ch.last_dimension) begin
                  count_in = '0;
                  n_in     = n_calc;
                  i_in     = IDX_W'(1);
                  j_in     = IDX_W'(2);
                  if (n_calc == IDX_W'(1)) begin
                     state_in = ST_SINGLE;
                  end else if (n_calc != '0) begin
                     state_in = ST_PAIR_A;
                  end
               end
            end
         end
         ST_PAIR_A: begin
            state_in = ST_PAIR_B;
         end
         ST_PAIR_B: begin
            dim_rd_addr  = j_ff;
            ctl.load_dim = 1'b1;
            state_in     = ST_PAIR_C;
         end
         ST_PAIR_C: begin
            ctl.mul_en = 1'b1;
            k_in       = i_ff;
            state_in   = ST_PAIR_D;
         end
         ST_PAIR_D: begin
            ctl.load_prod = 1'b1;
            state_in      = ST_K_RD;
         end
         ST_K_RD: begin
            dim_rd_addr = k_ff;
            cost_addr_a = cost_addr(i_ff, k_ff);
            state_in    = ST_K_MUL;
         end
         ST_K_MUL: begin
            ctl.mul_en     = 1'b1;
            ctl.acc_op     = ACC_PAIR;
            ctl.left_zero  = (k_ff == i_ff);
            ctl.right_zero = (k_ff + IDX_W'(1) == j_ff);
            state_in       = ST_K_ADD;
         end
         ST_K_ADD: begin
            ctl.acc_op = ACC_PROD;
            state_in   = ST_K_CMP;
         end
         ST_K_CMP: begin
            ctl.cmp_en  = 1'b1;
            ctl.first_k = (k_ff == i_ff);
            if (take) begin
               best_k_in = k_ff;
            end
            if (k_ff + IDX_W'(1) == j_ff) begin
               // Subchain done: store it and move to the next one.
               cost_wr_en = 1'b1;
               if (j_ff == n_ff) begin
                  if (i_ff == IDX_W'(1)) begin
                     j_in     = IDX_W'(2);
                     state_in = ST_DUMP_RD;
                  end else begin
                     j_in     = j_ff - i_ff + IDX_W'(2);
                     state_in = ST_PAIR_A;
                  end
                  i_in = IDX_W'(1);
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_PAIR_A;
               end
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_K_RD;
            end
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_LD;
         end
         ST_DUMP_LD: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_row_in   = OUT_IDX_W'(i_ff);
               rsp_col_in   = OUT_IDX_W'(j_ff);
               rsp_cost_in  = cost_rd_a.cost;
               rsp_split_in = cost_rd_a.split;
               rsp_last_in  = dump_last;
               if (dump_last) begin
                  state_in = ST_IDLE;
               end else if (j_ff == n_ff) begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = i_ff + IDX_W'(2);
                  state_in = ST_DUMP_RD;
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_DUMP_RD;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_row_in   = OUT_IDX_W'(1);
               rsp_col_in   = OUT_IDX_W'(1);
               rsp_cost_in  = '0;
               rsp_split_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The result register empties when its transaction completes.
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.row_index   = rsp_row_ff;
   assign rsp_ch.col_index   = rsp_col_ff;
   assign rsp_ch.min_cost    = rsp_cost_ff;
   assign rsp_ch.best_split  = rsp_split_ff;
   assign rsp_ch.last_result = rsp_last_ff;

   // The split under test always lies inside its subchain.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K_RD) |-> (k_ff >= i_ff && k_ff < j_ff))
      else $error("split index outside its subchain");

   // Every subchain that the search starts lies within the chain.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAIR_A) |-> (i_ff < j_ff && j_ff <= n_ff))
      else $error("subchain indices outside the chain");

   // The dimension count never passes the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("dimension count beyond the slots");

   // A new result is loaded only into a free or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten");

   // After the final result of a dump the block is ready for the next chain.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("sequencer not idle after the final result");

endmodule

FILE: hw/rtl/mcdp_dim_store.sv
// Dimension memory: one write port and one registered read port.
// Depends on mcdp_pkg for the dimension width.

module mcdp_dim_store import mcdp_pkg::*; #(
   parameter int SLOTS  = 9,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DIM_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DIM_W-1:0]  rd_data
);

   logic [DIM_W-1:0] dim_mem [SLOTS];
   logic [DIM_W-1:0] rd_data_ff;

   // Write on a stored dimension, read every cycle into the output register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dim_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= dim_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mcdp_cost_ram.sv
// Cost and split table: one write port and two registered read ports.
// Depends on mcdp_pkg for the entry type.

module mcdp_cost_ram import mcdp_pkg::*; #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output entry_type         rd_data_a,
   output entry_type         rd_data_b
);

   entry_type entry_mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   // One write and two reads per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= entry_mem[rd_addr_a];
      rd_b_ff <= entry_mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hw/rtl/mcdp_arith.sv
// Shared arithmetic unit: one 32x16 multiplier, one saturating adder and the
// running minimum of a split search. Depends on mcdp_pkg.

module mcdp_arith import mcdp_pkg::*; (
   input  logic              clock,
   input  arith_ctl_type     ctl,
   input  logic [DIM_W-1:0]  dim_rd,
   input  logic [COST_W-1:0] left_cost,
   input  logic [COST_W-1:0] right_cost,
   output logic              take,
   output logic [COST_W-1:0] acc,
   output logic [COST_W-1:0] best
);

   logic [MULA_W-1:0] mul_a_ff;
   logic [MULA_W-1:0] mul_a_in;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] product;
   logic [COST_W-1:0] acc_ff;
   logic [COST_W-1:0] acc_in;
   logic [COST_W-1:0] best_ff;
   logic [COST_W-1:0] best_in;
   logic [COST_W-1:0] add_a;
   logic [COST_W-1:0] add_b;
   logic [COST_W:0]   add_sum;
   logic [COST_W-1:0] add_sat;

   // The multiplier: first p[i-1]*p[j], then that product times p[k].
   assign product = mul_a_ff * dim_rd;

   // Operand selection for the shared saturating adder.
   always_comb begin
      add_a = acc_ff;
      add_b = COST_W'(prod_ff);
      if (ctl.acc_op == ACC_PAIR) begin
         add_a = ctl.left_zero ? '0 : left_cost;
         add_b = ctl.right_zero ? '0 : right_cost;
      end
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b};
   assign add_sat = add_sum[COST_W] ? COST_CAP : add_sum[COST_W-1:0];

   // The first split always wins; later ones only when strictly cheaper.
   assign take = ctl.first_k || (acc_ff < best_ff);

   // Next values of the operand, product, accumulator and minimum registers.
   always_comb begin
      mul_a_in = mul_a_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      best_in  = best_ff;
      if (ctl.load_dim) begin
         mul_a_in = MULA_W'(dim_rd);
      end else if (ctl.load_prod) begin
         mul_a_in = prod_ff[MULA_W-1:0];
      end
      if (ctl.mul_en) begin
         prod_in = product;
      end
      unique case (ctl.acc_op)
         ACC_PAIR, ACC_PROD: acc_in = add_sat;
         default:            acc_in = acc_ff;
      endcase
      if (ctl.cmp_en && take) begin
         best_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      best_ff  <= best_in;
   end

   assign acc  = acc_ff;
   assign best = best_ff;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the matrix chain order block (matrix_chain_order_dp).
// Depends on mcdp_pkg and the channel interfaces in mcdp_if; drives dimension chains,
// predicts every subchain cost and split, and checks each result transaction.
`timescale 1ns / 100ps

module tb_top;
   import mcdp_pkg::*;

   localparam int CHAIN_SLOTS  = 9;        // MAX_MATRICES + 1 stored dimensions
   localparam int MATRIX_LIMIT = 8;
   localparam int RANDOM_ITEMS = 350;
   localparam int TAIL_CYCLES  = 600;      // one full chain run plus margin
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [63:0] COST_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   // Value mixes for the random dimensions.
   typedef enum int {
      DIM_FULL,
      DIM_TIES,
      DIM_NARROW
   } dim_style_type;

   // Receiver backpressure patterns.
   typedef enum int {
      RX_STREAM,
      RX_RANDOM,
      RX_PERIODIC,
      RX_LONG
   } rx_pattern_type;

   // One pending input transaction; drain_first holds it back until all results are in.
   typedef struct {
      logic [DIM_W-1:0] dimension;
      logic             last_dimension;
      bit               drain_first;
   } dim_item_type;

   // One expected result transaction.
   typedef struct {
      logic [OUT_IDX_W-1:0] row_index;
      logic [OUT_IDX_W-1:0] col_index;
      logic [COST_W-1:0]    min_cost;
      logic [SPLIT_W-1:0]   best_split;
      logic                 last_result;
   } subchain_result_type;

   logic clock;
   logic reset;
   bit   run_failed = 1'b0;
   int   cycle_count = 0;

   dim_item_type        dim_item_q[$];
   subchain_result_type subchain_expect_q[$];

   // Predictor state: the stored chain dimensions and their count.
   logic [DIM_W-1:0] chain_dims [CHAIN_SLOTS];
   int               chain_len = 0;

   mcdp_req_if req_if ();
   mcdp_rsp_if rsp_if ();

   matrix_chain_order_dp #(.MAX_MATRICES(MATRIX_LIMIT)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Clock with a 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Cost addition that clamps at the top of the 63-bit range.
   function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] sum;
      sum = {1'b0, (a > COST_MAX) ? COST_MAX : a} + {1'b0, (b > COST_MAX) ? COST_MAX : b};
      return (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[63:0];
   endfunction

   // Stores one accepted dimension; on the marked one, solves the interval program
   // over the stored chain and queues the table dump in row-major order.
   task automatic record_dimension(input logic [DIM_W-1:0] dim, input logic mark);
      logic [63:0]         cost_tab [CHAIN_SLOTS][CHAIN_SLOTS];
      int                  split_tab [CHAIN_SLOTS][CHAIN_SLOTS];
      logic [63:0]         prod;
      logic [63:0]         trial;
      logic [63:0]         best;
      int                  best_k;
      int                  n;
      int                  j;
      subchain_result_type res;
      if (chain_len < CHAIN_SLOTS) begin
         chain_dims[chain_len] = dim;
         chain_len++;
      end
      if (!mark) return;
      n = (chain_len >= 1) ? chain_len - 1 : 0;
      chain_len = 0;
      if (n == 0) return;

      for (int i = 1; i <= n; i++) begin
         cost_tab[i][i] = 64'd0;
         split_tab[i][i] = 0;
      end
      // Fill subchains by increasing length; a tie keeps the smallest split.
      for (int span = 2; span <= n; span++) begin
         for (int i = 1; i + span - 1 <= n; i++) begin
            j = i + span - 1;
            best = 64'd0;
            best_k = 0;
            for (int k = i; k < j; k++) begin
               prod = 64'(chain_dims[i-1]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
               trial = clamp_add(clamp_add(cost_tab[i][k], cost_tab[k+1][j]), prod);
               if (k == i || trial < best) begin
                  best = trial;
                  best_k = k;
               end
            end
            cost_tab[i][j] = best;
            split_tab[i][j] = best_k & 7;
         end
      end

      // A single matrix dumps its one diagonal entry.
      if (n == 1) begin
         res.row_index   = 4'd1;
         res.col_index   = 4'd1;
         res.min_cost    = cost_tab[1][1][COST_W-1:0];
         res.best_split  = '0;
         res.last_result = 1'b1;
         subchain_expect_q.push_back(res);
         return;
      end
      for (int i = 1; i < n; i++) begin
         for (int jj = i + 1; jj <= n; jj++) begin
            res.row_index   = OUT_IDX_W'(i);
            res.col_index   = OUT_IDX_W'(jj);
            res.min_cost    = cost_tab[i][jj][COST_W-1:0];
            res.best_split  = SPLIT_W'(split_tab[i][jj]);
            res.last_result = (i == n - 1 && jj == n);
            subchain_expect_q.push_back(res);
         end
      end
   endtask

   task automatic add_item(input logic [DIM_W-1:0] dim, input logic mark, input bit drain);
      dim_item_type item;
      item.dimension      = dim;
      item.last_dimension = mark;
      item.drain_first    = drain;
      dim_item_q.push_back(item);
   endtask

   function automatic logic [DIM_W-1:0] pick_dimension(input dim_style_type style);
      case (style)
         DIM_TIES: begin
            return DIM_W'($urandom_range(1, 4));
         end
         DIM_NARROW: begin
            if ($urandom_range(0, 9) == 0) return '0;
            return DIM_W'($urandom_range(1, 300));
         end
         default: begin
            case ($urandom_range(0, 31))
               0: return '0;
               1: return '1;
               2: return DIM_W'(1);
               default: return DIM_W'($urandom_range(1, 65535));
            endcase
         end
      endcase
   endfunction

   // Queues one chain of random dimensions with the mark on its final entry.
   task automatic queue_chain(input int dims, input dim_style_type style, input bit drain);
      for (int idx = 0; idx < dims; idx++) begin
         add_item(pick_dimension(style), idx == dims - 1, drain && idx == 0);
      end
   endtask

   // Stimulus: a directed set of chains, then random chains.
   initial begin : stimulus
      int            kept;
      int            pick;
      int            dims;
      dim_style_type style;
      kept = 0;

      // A mark with a single stored dimension yields no result.
      add_item(16'd7, 1'b1, 1'b0);
      // One matrix: the single diagonal entry.
      add_item(16'hFFFF, 1'b0, 1'b0);
      add_item(16'hFFFF, 1'b1, 1'b0);
      // All-equal dimensions tie on every split.
      for (int idx = 0; idx < 4; idx++) add_item(16'd1, idx == 3, 1'b0);
      // A zero dimension is used as given.
      add_item(16'd5, 1'b0, 1'b0);
      add_item(16'd0, 1'b0, 1'b0);
      add_item(16'd7, 1'b1, 1'b0);
      // Full chain of largest dimensions, then extra ones (the marked one too) dropped.
      for (int idx = 0; idx < CHAIN_SLOTS; idx++) add_item(16'hFFFF, 1'b0, 1'b0);
      add_item(16'd1, 1'b0, 1'b0);
      add_item(16'd1, 1'b1, 1'b0);

      // Mostly well-formed chains; some empty and some overlong ones as noise.
      while (kept < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) dims = 1;
         else if (pick < 12) dims = $urandom_range(CHAIN_SLOTS + 1, CHAIN_SLOTS + 3);
         else dims = $urandom_range(2, CHAIN_SLOTS);
         style = dim_style_type'($urandom_range(0, 2));
         queue_chain(dims, style, kept == 0 || $urandom_range(0, 19) == 0);
         kept += (dims > CHAIN_SLOTS) ? CHAIN_SLOTS : dims;
      end
   end

   // Driver: presents dimensions in bursts with random gaps and predicts on acceptance.
   always @(posedge clock) begin : dimension_driver
      static int        burst_left = 0;
      static int        gap_left = 0;
      logic             offer;
      logic [DIM_W-1:0] dim;
      logic             mark;
      dim_item_type     item;
      offer = req_if.valid;
      dim   = req_if.dimension;
      mark  = req_if.last_dimension;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            record_dimension(req_if.dimension, req_if.last_dimension);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (dim_item_q.size() != 0 &&
                         !(dim_item_q[0].drain_first && subchain_expect_q.size() != 0)) begin
               item  = dim_item_q.pop_front();
               offer = 1'b1;
               dim   = item.dimension;
               mark  = item.last_dimension;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end
      req_if.valid          <= offer;
      req_if.dimension      <= dim;
      req_if.last_dimension <= mark;
   end

   // Monitor: checks each accepted result transaction and drives the receiver's stalls.
   always @(posedge clock) begin : result_monitor
      static rx_pattern_type rx_mode = RX_STREAM;
      static int             mode_left = 0;
      static int             phase = 0;
      subchain_result_type   want;
      logic                  take;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (subchain_expect_q.size() == 0) begin
            $error("unexpected result row_index %0d col_index %0d",
                   rsp_if.row_index, rsp_if.col_index);
            run_failed = 1'b1;
         end else begin
            want = subchain_expect_q.pop_front();
            if (rsp_if.row_index !== want.row_index) begin
               $error("row_index expected %0d actual %0d", want.row_index, rsp_if.row_index);
               run_failed = 1'b1;
            end
            if (rsp_if.col_index !== want.col_index) begin
               $error("col_index expected %0d actual %0d", want.col_index, rsp_if.col_index);
               run_failed = 1'b1;
            end
            if (rsp_if.min_cost !== want.min_cost) begin
               $error("min_cost expected %0d actual %0d", want.min_cost, rsp_if.min_cost);
               run_failed = 1'b1;
            end
            if (rsp_if.best_split !== want.best_split) begin
               $error("best_split expected %0d actual %0d", want.best_split,
                      rsp_if.best_split);
               run_failed = 1'b1;
            end
            if (rsp_if.last_result !== want.last_result) begin
               $error("last_result expected %0d actual %0d", want.last_result,
                      rsp_if.last_result);
               run_failed = 1'b1;
            end
         end
      end

      // The stall pattern is picked anew whenever its count runs out.
      if (mode_left == 0) begin
         rx_mode   = rx_pattern_type'($urandom_range(0, 3));
         mode_left = $urandom_range(40, 300);
      end else begin
         mode_left--;
      end
      phase++;
      case (rx_mode)
         RX_STREAM:   take = 1'b1;
         RX_RANDOM:   take = 1'($urandom_range(0, 1));
         RX_PERIODIC: take = (phase % 5) != 0;
         default:     take = (phase % 40) >= 20;
      endcase
      rsp_if.ready <= take;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Reset, then wait for all traffic to drain and report.
   initial begin : run_control
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (dim_item_q.size() == 0 && !req_if.valid);
      while (subchain_expect_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (subchain_expect_q.size() != 0) begin
         $error("%0d expected results never arrived", subchain_expect_q.size());
         run_failed = 1'b1;
      end
      if (!run_failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
